// ----- rtl/core/cpdma_pkg.sv -----
// Shared types and constants for the coprocessor register file with DMA snoop.
// Used by the decoder, the shadow memory and the top level.
package cpdma_pkg;

   localparam int DMA_CHANNELS_DEF = 8;

   localparam logic [15:0] OWN_LO   = 16'h4800;
   localparam logic [15:0] OWN_HI   = 16'h4807;
   localparam logic [15:0] SNOOP_LO = 16'h4300;
   localparam logic [15:0] SNOOP_HI = 16'h437A;

   localparam int ADDR_W   = 24;
   localparam int LEN_W    = 16;
   localparam int SHADOW_W = ADDR_W + LEN_W;

   typedef enum logic [2:0] {
      OFF_ALLOW = 3'd0,
      OFF_NEXT  = 3'd1,
      OFF_RSV2  = 3'd2,
      OFF_RSV3  = 3'd3,
      OFF_BANK0 = 3'd4,
      OFF_BANK1 = 3'd5,
      OFF_BANK2 = 3'd6,
      OFF_BANK3 = 3'd7
   } own_off_type;

   typedef enum logic [3:0] {
      NIB_ADDR_LO  = 4'h2,
      NIB_ADDR_MID = 4'h3,
      NIB_ADDR_HI  = 4'h4,
      NIB_LEN_LO   = 4'h5,
      NIB_LEN_HI   = 4'h6
   } snoop_nib_type;

   typedef struct packed {
      logic        is_write;
      logic        own;
      own_off_type off;
      logic        fwd;
      logic        snoop;
      logic [3:0]  nib;
   } req_dec_type;

endpackage

// ----- rtl/core/cpdma_decode.sv -----
// Request decoder: classifies a bus access into own register, snoop or forward.
// Depends on cpdma_pkg.
module cpdma_decode
   import cpdma_pkg::*;
(
   input  logic        action,
   input  logic [15:0] bus_address,
   output req_dec_type dec
);

   logic own;
   logic in_window;
   logic nib_ok;

   always_comb begin
      own       = (bus_address >= OWN_LO) && (bus_address <= OWN_HI);
      in_window = (bus_address >= SNOOP_LO) && (bus_address <= SNOOP_HI);
      nib_ok    = (bus_address[3:0] >= 4'(NIB_ADDR_LO)) && (bus_address[3:0] <= 4'(NIB_LEN_HI));
      dec.is_write = action;
      dec.own      = own;
      dec.off      = own_off_type'(bus_address[2:0]);
      dec.nib      = bus_address[3:0];
      dec.snoop    = action && !own && in_window && nib_ok;
      if (!own) begin
         dec.fwd = 1'b1;
      end else if (!action) begin
         dec.fwd = (bus_address[2:0] == 3'(OFF_RSV2)) || (bus_address[2:0] == 3'(OFF_RSV3));
      end else begin
         dec.fwd = 1'b0;
      end
   end

endmodule

// ----- rtl/core/cpdma_shadow_ram.sv -----
// Shadow memory for per-channel DMA address and length, with registered read data.
// Entries read as zero until first written. Depends on cpdma_pkg.
module cpdma_shadow_ram
   import cpdma_pkg::*;
#(
   parameter int DEPTH = DMA_CHANNELS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [SHADOW_W-1:0] rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SHADOW_W-1:0] wr_data
);

   logic [SHADOW_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   logic [DEPTH-1:0]    valid_in;
   logic [SHADOW_W-1:0] rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/coprocessor_register_file_dma_snoop.sv -----
// Top level: coprocessor register file with DMA register snoop.
// Uses cpdma_pkg, cpdma_decode and cpdma_shadow_ram.
//
//   channel   direction  ports
//   request   in         req_valid, req_stall, req_action, req_bus_address, req_write_byte
//   response  out        rsp_valid, rsp_stall, rsp_read_byte, rsp_forwarded, rsp_snoop_*,
//                        rsp_channel_address, rsp_channel_length
//
// One request per cycle while the response side does not stall; an accepted request is
// registered with its shadow read in the read stage, then merged, written back and loaded
// into the response register when the read stage advances.
// A write-back is forwarded to the next request of the same channel.
// Reset is synchronous; the shadow memory needs no clearing pass (per-entry valid bits).
// A stalled response holds one more request in the read stage, then stalls requests.
module coprocessor_register_file_dma_snoop
   import cpdma_pkg::*;
#(
   parameter int DMA_CHANNELS = DMA_CHANNELS_DEF,
   parameter int CH_W         = $clog2(DMA_CHANNELS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [15:0]       req_bus_address,
   input  logic [7:0]        req_write_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_forwarded,
   output logic              rsp_snoop_hit,
   output logic [CH_W-1:0]   rsp_snoop_channel,
   output logic [ADDR_W-1:0] rsp_channel_address,
   output logic [LEN_W-1:0]  rsp_channel_length
);

   req_dec_type         req_dec;
   logic                req_accept;
   logic [CH_W-1:0]     req_chan;

   logic                s1_valid_ff, s1_valid_in;
   req_dec_type         s1_dec_ff;
   logic [CH_W-1:0]     s1_chan_ff;
   logic [7:0]          s1_byte_ff;
   logic                s1_adv;

   logic [SHADOW_W-1:0] rd_data;
   logic [SHADOW_W-1:0] base;
   logic [SHADOW_W-1:0] merged;
   logic                wb_en;

   logic                wb_valid_ff;
   logic [CH_W-1:0]     wb_chan_ff;
   logic [SHADOW_W-1:0] wb_data_ff;

   logic [7:0]          allow_ff, allow_in;
   logic [7:0]          next_ff, next_in;
   logic [7:0]          bank_ff [4];
   logic [7:0]          bank_in [4];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rd_byte;
   logic [7:0]          rsp_read_byte_ff;
   logic                rsp_forwarded_ff;
   logic                rsp_snoop_hit_ff;
   logic [CH_W-1:0]     rsp_snoop_channel_ff;
   logic [SHADOW_W-1:0] rsp_shadow_ff;

   cpdma_decode u_decode (
      .action      (req_action),
      .bus_address (req_bus_address),
      .dec         (req_dec)
   );

   assign req_chan   = req_bus_address[4 +: CH_W];
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;
   assign wb_en      = s1_adv && s1_dec_ff.snoop;

   cpdma_shadow_ram #(
      .DEPTH (DMA_CHANNELS)
   ) u_shadow (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_chan),
      .rd_data (rd_data),
      .wr_en   (wb_en),
      .wr_addr (s1_chan_ff),
      .wr_data (merged)
   );

   // merge the written byte into the forwarded or stored shadow entry
   always_comb begin
      base = (wb_valid_ff && (wb_chan_ff == s1_chan_ff)) ? wb_data_ff : rd_data;
      merged = base;
      case (s1_dec_ff.nib)
         NIB_ADDR_LO:  merged[LEN_W +: 8]      = s1_byte_ff;
         NIB_ADDR_MID: merged[LEN_W + 8 +: 8]  = s1_byte_ff;
         NIB_ADDR_HI:  merged[LEN_W + 16 +: 8] = s1_byte_ff;
         NIB_LEN_LO:   merged[0 +: 8]          = s1_byte_ff;
         NIB_LEN_HI:   merged[8 +: 8]          = s1_byte_ff;
         default:      merged = base;
      endcase
   end

   // own register file: read and write in the merge stage
   always_comb begin
      allow_in = allow_ff;
      next_in  = next_ff;
      for (int i = 0; i < 4; i++) begin
         bank_in[i] = bank_ff[i];
      end
      rd_byte = '0;
      if (s1_adv && s1_dec_ff.own) begin
         unique case (s1_dec_ff.off) inside
            OFF_ALLOW: begin
               if (s1_dec_ff.is_write) allow_in = s1_byte_ff;
               else rd_byte = allow_ff;
            end
            OFF_NEXT: begin
               if (s1_dec_ff.is_write) next_in = s1_byte_ff;
               else rd_byte = next_ff;
            end
            OFF_BANK0, OFF_BANK1, OFF_BANK2, OFF_BANK3: begin
               if (s1_dec_ff.is_write) bank_in[s1_dec_ff.off[1:0]] = s1_byte_ff;
               else rd_byte = bank_ff[s1_dec_ff.off[1:0]];
            end
            default: rd_byte = '0;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wb_valid_ff  <= 1'b0;
         allow_ff     <= '0;
         next_ff      <= '0;
         for (int i = 0; i < 4; i++) begin
            bank_ff[i] <= 8'(i);
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         allow_ff     <= allow_in;
         next_ff      <= next_in;
         for (int i = 0; i < 4; i++) begin
            bank_ff[i] <= bank_in[i];
         end
         if (wb_en) begin
            wb_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_dec_ff  <= req_dec;
         s1_chan_ff <= req_chan;
         s1_byte_ff <= req_write_byte;
      end
      if (wb_en) begin
         wb_chan_ff <= s1_chan_ff;
         wb_data_ff <= merged;
      end
      if (s1_adv) begin
         rsp_read_byte_ff     <= rd_byte;
         rsp_forwarded_ff     <= s1_dec_ff.fwd;
         rsp_snoop_hit_ff     <= s1_dec_ff.snoop;
         rsp_snoop_channel_ff <= s1_dec_ff.snoop ? s1_chan_ff : '0;
         rsp_shadow_ff        <= s1_dec_ff.snoop ? merged : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_byte       = rsp_read_byte_ff;
   assign rsp_forwarded       = rsp_forwarded_ff;
   assign rsp_snoop_hit       = rsp_snoop_hit_ff;
   assign rsp_snoop_channel   = rsp_snoop_channel_ff;
   assign rsp_channel_address = rsp_shadow_ff[LEN_W +: ADDR_W];
   assign rsp_channel_length  = rsp_shadow_ff[0 +: LEN_W];

endmodule

// ----- rtl/core/cpdma_checker.sv -----
// Port-level checker for the coprocessor register file with DMA snoop.
// Bound to the top level; depends on cpdma_pkg.
module cpdma_checker
   import cpdma_pkg::*;
#(
   parameter int CH_W = $clog2(DMA_CHANNELS_DEF)
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [7:0]        rsp_read_byte,
   input logic              rsp_forwarded,
   input logic              rsp_snoop_hit,
   input logic [CH_W-1:0]   rsp_snoop_channel,
   input logic [ADDR_W-1:0] rsp_channel_address,
   input logic [LEN_W-1:0]  rsp_channel_length
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_byte)
         && $stable(rsp_snoop_hit) && $stable(rsp_channel_address))
      else $error("stalled response changed");

   a_snoop_forwarded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_snoop_hit |-> rsp_forwarded && rsp_read_byte == 8'd0)
      else $error("snoop response not forwarded or carries read data");

   a_no_snoop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_snoop_hit |-> rsp_snoop_channel == '0
         && rsp_channel_address == '0 && rsp_channel_length == '0)
      else $error("snoop fields set without a hit");

endmodule

bind coprocessor_register_file_dma_snoop cpdma_checker #(
   .CH_W (CH_W)
) u_cpdma_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_read_byte       (rsp_read_byte),
   .rsp_forwarded       (rsp_forwarded),
   .rsp_snoop_hit       (rsp_snoop_hit),
   .rsp_snoop_channel   (rsp_snoop_channel),
   .rsp_channel_address (rsp_channel_address),
   .rsp_channel_length  (rsp_channel_length)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for coprocessor_register_file_dma_snoop: bus accesses go in,
// and each response is compared with an in-bench prediction of the registers and DMA shadows.
// Depends on cpdma_pkg and the top level RTL only.
`timescale 1ns / 100ps

module testbench;
   import cpdma_pkg::*;

   localparam logic ACT_READ    = 1'b0;
   localparam logic ACT_WRITE   = 1'b1;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 10;

   typedef struct packed {
      logic [7:0]        read_byte;
      logic              forwarded;
      logic              snoop_hit;
      logic [2:0]        channel;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
   } bus_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = ACT_READ;
   logic [15:0]       req_bus_address = '0;
   logic [7:0]        req_write_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_read_byte;
   logic              rsp_forwarded;
   logic              rsp_snoop_hit;
   logic [2:0]        rsp_snoop_channel;
   logic [ADDR_W-1:0] rsp_channel_address;
   logic [LEN_W-1:0]  rsp_channel_length;

   logic [7:0]        allow_reg;
   logic [7:0]        next_reg;
   logic [7:0]        bank_reg [4];
   logic [ADDR_W-1:0] addr_shadow [8];
   logic [LEN_W-1:0]  len_shadow [8];

   bus_result_type expected_results [$];
   bit          idle_on = 1'b0;
   int          failures = 0;
   int          responses_checked = 0;
   int          reads_sent = 0;
   int          writes_sent = 0;
   int          shadow_updates = 0;
   int          forwarded_count = 0;
   int          cycle_count = 0;
   int          stall_left = 0;

   coprocessor_register_file_dma_snoop i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_bus_address     (req_bus_address),
      .req_write_byte      (req_write_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_forwarded       (rsp_forwarded),
      .rsp_snoop_hit       (rsp_snoop_hit),
      .rsp_snoop_channel   (rsp_snoop_channel),
      .rsp_channel_address (rsp_channel_address),
      .rsp_channel_length  (rsp_channel_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void reset_registers();
      allow_reg = '0;
      next_reg  = '0;
      for (int i = 0; i < 4; i++) bank_reg[i] = 8'(i);
      for (int i = 0; i < 8; i++) begin
         addr_shadow[i] = '0;
         len_shadow[i]  = '0;
      end
   endfunction

   function automatic bus_result_type model_bus_access(logic is_write, logic [15:0] addr,
                                                       logic [7:0] data);
      bus_result_type r;
      logic        own;
      own_off_type off;
      logic [2:0]  ch;
      r   = '0;
      own = (addr >= OWN_LO) && (addr <= OWN_HI);
      off = own_off_type'(addr[2:0]);
      ch  = addr[6:4];
      if (!is_write) begin
         if (!own) begin
            r.forwarded = 1'b1;
         end else begin
            case (off) inside
               OFF_ALLOW:          r.read_byte = allow_reg;
               OFF_NEXT:           r.read_byte = next_reg;
               OFF_RSV2, OFF_RSV3: r.forwarded = 1'b1;
               default:            r.read_byte = bank_reg[addr[1:0]];
            endcase
         end
      end else if (own) begin
         case (off) inside
            OFF_ALLOW:          allow_reg = data;
            OFF_NEXT:           next_reg = data;
            OFF_RSV2, OFF_RSV3: begin end
            default:            bank_reg[addr[1:0]] = data;
         endcase
      end else begin
         r.forwarded = 1'b1;
         if (addr >= SNOOP_LO && addr <= SNOOP_HI) begin
            r.snoop_hit = 1'b1;
            case (snoop_nib_type'(addr[3:0]))
               NIB_ADDR_LO:  addr_shadow[ch][7:0]   = data;
               NIB_ADDR_MID: addr_shadow[ch][15:8]  = data;
               NIB_ADDR_HI:  addr_shadow[ch][23:16] = data;
               NIB_LEN_LO:   len_shadow[ch][7:0]    = data;
               NIB_LEN_HI:   len_shadow[ch][15:8]   = data;
               default:      r.snoop_hit = 1'b0;
            endcase
            if (r.snoop_hit) begin
               r.channel = ch;
               r.address = addr_shadow[ch];
               r.length  = len_shadow[ch];
            end
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [15:0] own_addr(own_off_type off);
      return OWN_LO | 16'(off);
   endfunction

   function automatic logic [15:0] snoop_addr(logic [2:0] ch, logic [3:0] nib);
      return SNOOP_LO | {8'h00, 1'b0, ch, nib};
   endfunction

   task automatic send_request(logic is_write, logic [15:0] addr, logic [7:0] data);
      bus_result_type want;
      int          gap;
      req_valid       <= 1'b1;
      req_action      <= is_write;
      req_bus_address <= addr;
      req_write_byte  <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = model_bus_access(is_write, addr, data);
      expected_results.push_back(want);
      if (is_write) writes_sent++;
      else reads_sent++;
      if (want.snoop_hit) shadow_updates++;
      if (want.forwarded) forwarded_count++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      bus_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("read_byte", 24'(want.read_byte), 24'(rsp_read_byte));
            check_field("forwarded", 24'(want.forwarded), 24'(rsp_forwarded));
            check_field("snoop_hit", 24'(want.snoop_hit), 24'(rsp_snoop_hit));
            check_field("snoop_channel", 24'(want.channel), 24'(rsp_snoop_channel));
            check_field("channel_address", want.address, rsp_channel_address);
            check_field("channel_length", 24'(want.length), 24'(rsp_channel_length));
            responses_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  expected_results.size());
         $display("coprocessor_register_file_dma_snoop test failed");
         $finish;
      end
   end

   task automatic test_reset_state();
      for (int i = 0; i < 8; i++) send_request(ACT_READ, OWN_LO + 16'(i), 8'h00);
   endtask

   task automatic test_own_registers();
      send_request(ACT_WRITE, own_addr(OFF_ALLOW), 8'hFF);
      send_request(ACT_WRITE, own_addr(OFF_NEXT), 8'h00);
      send_request(ACT_WRITE, own_addr(OFF_RSV2), 8'hA5);
      send_request(ACT_WRITE, own_addr(OFF_BANK3), 8'hFF);
      send_request(ACT_READ, own_addr(OFF_ALLOW), 8'hFF);
      send_request(ACT_READ, own_addr(OFF_BANK3), 8'h00);
      send_request(ACT_READ, OWN_HI + 16'd1, 8'h00);
      send_request(ACT_WRITE, OWN_LO - 16'd1, 8'h3C);
   endtask

   task automatic test_dma_snoop();
      send_request(ACT_WRITE, snoop_addr(3'd0, NIB_ADDR_LO), 8'hFF);
      send_request(ACT_WRITE, snoop_addr(3'd0, NIB_ADDR_MID), 8'h00);
      send_request(ACT_WRITE, snoop_addr(3'd0, NIB_ADDR_HI), 8'hFF);
      send_request(ACT_WRITE, snoop_addr(3'd7, NIB_LEN_LO), 8'hFF);
      send_request(ACT_WRITE, snoop_addr(3'd7, NIB_LEN_HI), 8'h80);
      send_request(ACT_WRITE, snoop_addr(3'd7, 4'h7), 8'h11);
      send_request(ACT_WRITE, SNOOP_HI, 8'h22);
      send_request(ACT_WRITE, SNOOP_LO - 16'd1, 8'h33);
      send_request(ACT_READ, snoop_addr(3'd0, NIB_ADDR_LO), 8'h00);
      send_request(ACT_WRITE, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_random_traffic(int count);
      int          roll;
      logic [3:0]  nib;
      logic [15:0] addr;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            nib = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(NIB_ADDR_LO, NIB_LEN_HI))
                                             : 4'($urandom);
            send_request(ACT_WRITE, snoop_addr(3'($urandom), nib), 8'($urandom));
         end else if (roll < 72) begin
            send_request(1'($urandom), OWN_LO + 16'($urandom_range(0, 7)), 8'($urandom));
         end else if (roll < 80) begin
            addr = snoop_addr(3'($urandom), 4'($urandom));
            send_request(ACT_READ, addr, 8'($urandom));
         end else begin
            send_request(1'($urandom), 16'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic test_back_to_back(int count);
      idle_on = 1'b0;
      test_random_traffic(count);
      idle_on = 1'b1;
   endtask

   initial begin
      reset_registers();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_own_registers();
      idle_on = 1'b1;
      test_dma_snoop();
      test_random_traffic(400);
      wait_for_drain();
      test_back_to_back(150);
      test_random_traffic(350);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d responses: %0d reads, %0d writes, %0d forwarded accesses,",
               responses_checked, reads_sent, writes_sent, forwarded_count);
      $display("%0d DMA shadow updates, with random stalls on both channels.", shadow_updates);
      if (failures == 0) begin
         $display("coprocessor_register_file_dma_snoop test passed");
      end else begin
         $display("coprocessor_register_file_dma_snoop test failed");
      end
      $finish;
   end

endmodule
